// File: rtl/flt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flt_pkg;

	localparam int unsigned FLOW_ENTRIES_DEF = 1024;

	// key = {source_address, destination_address, source_port, destination_port}
	localparam int unsigned KEY_W       = 96;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned IDX_OUT_W   = 10;
	localparam int unsigned OUT_DATA_W  = 48;
	localparam int unsigned OUT_USER_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [KEY_W-1:0]   flow_key_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COUNT,
		ST_MISS
	} flt_state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} key_op_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic fresh;   // write the first count of a new flow
	} cnt_op_t;

endpackage

`default_nettype wire

// File: rtl/flt_key_store.sv
`timescale 1ns / 1ps
`default_nettype none

module flt_key_store #(
	parameter int unsigned FLOW_ENTRIES = flt_pkg::FLOW_ENTRIES_DEF
) (
	input  wire                  clk,
	input  flt_pkg::key_op_t     op,
	input  wire  [((FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1)-1:0] rd_addr,
	input  wire  [((FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1)-1:0] wr_addr,
	input  flt_pkg::flow_key_t   wr_key,
	input  flt_pkg::flow_key_t   cmp_key,
	output logic                 hit
);
	import flt_pkg::*;

	flow_key_t key_mem_q [FLOW_ENTRIES];
	flow_key_t rd_key_q;

	always_ff @(posedge clk) begin
		if (op.wr) begin
			key_mem_q[wr_addr] <= wr_key;
		end
		if (op.rd) begin
			rd_key_q <= key_mem_q[rd_addr];
		end
	end

	assign hit = (rd_key_q == cmp_key);

endmodule

`default_nettype wire

// File: rtl/flt_count_store.sv
`timescale 1ns / 1ps
`default_nettype none

module flt_count_store #(
	parameter int unsigned FLOW_ENTRIES = flt_pkg::FLOW_ENTRIES_DEF
) (
	input  wire                  clk,
	input  flt_pkg::cnt_op_t     op,
	input  wire  [((FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1)-1:0] rd_addr,
	input  wire  [((FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1)-1:0] wr_addr,
	output flt_pkg::count_t      cnt_next
);
	import flt_pkg::*;

	count_t cnt_mem_q [FLOW_ENTRIES];
	count_t rd_cnt_q;

	// saturating increment of the count read last; a new flow starts at one
	always_comb begin
		if (op.fresh) begin
			cnt_next = count_t'(1);
		end else if (rd_cnt_q == COUNT_MAX) begin
			cnt_next = COUNT_MAX;
		end else begin
			cnt_next = rd_cnt_q + count_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (op.wr) begin
			cnt_mem_q[wr_addr] <= cnt_next;
		end
		if (op.rd) begin
			rd_cnt_q <= cnt_mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/flt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module flt_ctrl #(
	parameter int unsigned FLOW_ENTRIES = flt_pkg::FLOW_ENTRIES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  flt_pkg::flow_key_t   s_key,
	output flt_pkg::flow_key_t   cur_key,
	output flt_pkg::key_op_t     key_op,
	output logic [((FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1)-1:0] key_rd_addr,
	input  wire                  key_hit,
	output flt_pkg::cnt_op_t     cnt_op,
	output logic [((FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1)-1:0] cnt_rd_addr,
	output logic [((FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1)-1:0] wr_addr,
	input  flt_pkg::count_t      cnt_next,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [flt_pkg::IDX_OUT_W-1:0] res_idx,
	output flt_pkg::count_t      res_cnt,
	output logic                 res_new,
	output logic                 res_full
);
	import flt_pkg::*;

	localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int unsigned USE_W = $clog2(FLOW_ENTRIES + 1);
	localparam logic [USE_W-1:0] USE_MAX = USE_W'(FLOW_ENTRIES);

	flt_state_t        state_q, state_d;
	flow_key_t         key_q;
	logic [IDX_W-1:0]  scan_q, scan_d;
	logic [USE_W-1:0]  used_q;
	logic [USE_W-1:0]  scan_nxt;
	logic              scan_last;
	logic              tbl_full;
	logic              out_free;
	logic              accept;
	logic              used_inc;
	logic              load_out;
	logic              load_full;
	logic              load_new;
	logic [IDX_W-1:0]  idx_src;
	logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
	logic              m_tvalid_q;

	assign scan_nxt  = USE_W'(scan_q) + USE_W'(1);
	assign scan_last = (scan_nxt == used_q);
	assign tbl_full  = (used_q == USE_MAX);
	assign out_free  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cur_key   = key_q;

	always_comb begin
		state_d     = state_q;
		scan_d      = scan_q;
		s_tready    = 1'b0;
		key_op      = '0;
		cnt_op      = '0;
		key_rd_addr = '0;
		cnt_rd_addr = scan_q;
		wr_addr     = used_q[IDX_W-1:0];
		used_inc    = 1'b0;
		load_out    = 1'b0;
		load_full   = 1'b0;
		load_new    = 1'b0;
		idx_src     = scan_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					key_op.rd = 1'b1;
					scan_d    = '0;
					state_d   = (used_q == '0) ? ST_MISS : ST_SCAN;
				end
			end
			ST_SCAN: begin
				// read of slot scan_q is back; on a miss short of the last used slot, fetch the next one
				if (key_hit) begin
					cnt_op.rd = 1'b1;
					state_d   = ST_COUNT;
				end else if (scan_last) begin
					state_d = ST_MISS;
				end else begin
					key_op.rd   = 1'b1;
					key_rd_addr = scan_nxt[IDX_W-1:0];
					scan_d      = scan_nxt[IDX_W-1:0];
				end
			end
			ST_COUNT: begin
				wr_addr = scan_q;
				if (out_free) begin
					cnt_op.wr = 1'b1;
					load_out  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_MISS: begin
				idx_src = used_q[IDX_W-1:0];
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
					if (tbl_full) begin
						load_full = 1'b1;
					end else begin
						key_op.wr    = 1'b1;
						cnt_op.wr    = 1'b1;
						cnt_op.fresh = 1'b1;
						used_inc     = 1'b1;
						load_new     = 1'b1;
					end
				end else begin
					cnt_op.fresh = !tbl_full;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idx_ext = {{IDX_OUT_W{1'b0}}, idx_src};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (used_inc) begin
				used_q <= used_q + USE_W'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		if (accept) begin
			key_q <= s_key;
		end
		if (load_out) begin
			res_full <= load_full;
			res_new  <= load_new;
			res_idx  <= load_full ? '0 : idx_ext[IDX_OUT_W-1:0];
			res_cnt  <= load_full ? '0 : cnt_next;
		end
	end

	assign m_tvalid = m_tvalid_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USE_MAX)
		else $error("flow count beyond table size");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_nxt <= used_q)
		else $error("scan past occupied slots");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MISS && out_free && !tbl_full) |=> used_q == $past(used_q) + USE_W'(1))
		else $error("insert did not take a slot");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_full) |-> (res_idx == '0 && res_cnt == '0 && !res_new))
		else $error("dropped packet carries flow data");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && load_full) |-> tbl_full)
		else $error("drop while slots remain");

endmodule

`default_nettype wire

// File: rtl/flow_tuple_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// Exact-match flow table with a saturating packet count per flow.
// Slave side: one beat per packet, s_tdata holds the TCP 4-tuple. Master side:
// one beat per packet with the flow slot, its updated count and two flags.
// Keys and counts live in two single-port-style synchronous memories of
// FLOW_ENTRIES words. The key memory is read one slot per cycle, slot 0
// upward, and compared with the held tuple; the first hit reads the count,
// which is incremented and written back. With no hit the tuple goes into the
// next free slot with a count of one; with no free slot the packet is
// reported with table_full set and nothing else.
// One packet is in work at a time: the next tuple is accepted only after the
// held one has been compared with the stored keys (an empty table skips the
// scan) and its result has been loaded into the output register.
// The result sits in an output register; the next beat is taken while it
// waits, and a stalled receiver holds only the write-back of the next result.
// Reset empties the table at once (no clearing pass); memory contents are
// don't-care until a slot is inserted.
module flow_tuple_counter #(
	parameter int unsigned FLOW_ENTRIES = flt_pkg::FLOW_ENTRIES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// source_address, destination_address, source_port, destination_port
	input  wire  [flt_pkg::KEY_W-1:0]         s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// flow_index, packet_count, zero fill
	output logic [flt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// new_flow, table_full
	output logic [flt_pkg::OUT_USER_W-1:0]    m_tuser
);
	import flt_pkg::*;

	localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

	flow_key_t              cur_key;
	key_op_t                key_op;
	cnt_op_t                cnt_op;
	logic [IDX_W-1:0]       key_rd_addr;
	logic [IDX_W-1:0]       cnt_rd_addr;
	logic [IDX_W-1:0]       wr_addr;
	logic                   key_hit;
	count_t                 cnt_next;
	logic [IDX_OUT_W-1:0]   res_idx;
	count_t                 res_cnt;
	logic                   res_new;
	logic                   res_full;

	flt_ctrl #(
		.FLOW_ENTRIES (FLOW_ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_key       (s_tdata),
		.cur_key     (cur_key),
		.key_op      (key_op),
		.key_rd_addr (key_rd_addr),
		.key_hit     (key_hit),
		.cnt_op      (cnt_op),
		.cnt_rd_addr (cnt_rd_addr),
		.wr_addr     (wr_addr),
		.cnt_next    (cnt_next),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.res_idx     (res_idx),
		.res_cnt     (res_cnt),
		.res_new     (res_new),
		.res_full    (res_full)
	);

	flt_key_store #(
		.FLOW_ENTRIES (FLOW_ENTRIES)
	) u_key_store (
		.clk     (clk),
		.op      (key_op),
		.rd_addr (key_rd_addr),
		.wr_addr (wr_addr),
		.wr_key  (cur_key),
		.cmp_key (cur_key),
		.hit     (key_hit)
	);

	flt_count_store #(
		.FLOW_ENTRIES (FLOW_ENTRIES)
	) u_count_store (
		.clk      (clk),
		.op       (cnt_op),
		.rd_addr  (cnt_rd_addr),
		.wr_addr  (wr_addr),
		.cnt_next (cnt_next)
	);

	assign m_tdata = {{(OUT_DATA_W - IDX_OUT_W - COUNT_W){1'b0}}, res_cnt, res_idx};
	assign m_tuser = {res_full, res_new};

endmodule

`default_nettype wire
